>>> hw/rtl/mtf_pkg.sv
// Shared types and constants for the MIDI tempo and flash light controller.
// Used by mtf_div and midi_tempo_flash_light_controller_core; no dependencies.
`default_nettype none
package mtf_pkg;

  // Request type codes
  localparam logic [2:0] REQ_CLOCK    = 3'd0;
  localparam logic [2:0] REQ_START    = 3'd1;
  localparam logic [2:0] REQ_CTRL     = 3'd2;
  localparam logic [2:0] REQ_NOTE_ON  = 3'd3;
  localparam logic [2:0] REQ_NOTE_OFF = 3'd4;
  localparam logic [2:0] REQ_FRAME    = 3'd5;

  localparam logic [4:0] LAST_CLOCK   = 5'd23;
  localparam logic [6:0] FLASH_NOTE   = 7'd126;
  localparam logic [6:0] CC_RED       = 7'd20;
  localparam logic [6:0] CC_GREEN     = 7'd21;
  localparam logic [6:0] CC_BLUE      = 7'd22;

  localparam int unsigned FT_W   = 18;          // (16b period * 4b speed) >> 2
  localparam int unsigned QUOT_W = 8;
  localparam int unsigned DVD_W  = FT_W + QUOT_W; // colour * (ft - e)
  localparam int unsigned ELAP_W = 20;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCALE,
    ST_SEL,
    ST_MUL,
    ST_DSTART,
    ST_DWAIT,
    ST_EMIT
  } state_e;

endpackage
`default_nettype wire

>>> hw/rtl/midi_tempo_flash_light_controller_core.sv
// MIDI tempo and flash light controller, top level.
// Depends on mtf_pkg and mtf_div.
//
// Every request except a frame tick is taken while idle and gives no result.
// A frame tick gives one result. With the flash off it goes straight to the
// output; with the flash running it first takes one multiply for the fade
// length and a compare, and if elapsed time is still below the fade length it
// then runs per colour one multiply and a division in the shared bit-serial
// divider. The input stalls while a frame tick is in progress; a finished result
// sits in the output register so the next request can be taken while it waits.
`default_nettype none
module midi_tempo_flash_light_controller_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [4:0]  cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [2:0]  req_type_i,
  input  wire logic [4:0]  channel_i,
  input  wire logic [6:0]  number_i,
  input  wire logic [6:0]  value_i,
  input  wire logic [31:0] now_ms_i,
  input  wire logic [15:0] frame_ms_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [7:0]       red_o,
  output logic [7:0]       green_o,
  output logic [7:0]       blue_o,
  output logic             indicator_o,
  output logic [15:0]      beat_period_o
);
  import mtf_pkg::*;

  state_e state_q, state_d;

  logic [4:0]        listen_q;
  logic [4:0]        clk_cnt_q;
  logic [31:0]       clk_start_q;
  logic [15:0]       period_q;
  logic [15:0]       last_frame_q;
  logic [15:0]       frame_q;
  logic [7:0]        col_r_q, col_g_q, col_b_q;
  logic              running_q;
  logic [3:0]        speed_q;
  logic [ELAP_W-1:0] elapsed_q;
  logic              lamp_q;

  logic [FT_W-1:0]   ft_q;
  logic [DVD_W-1:0]  prod_q;
  logic [1:0]        idx_q;
  logic [7:0]        res_q [3];

  logic              out_valid_q;
  logic [7:0]        out_r_q, out_g_q, out_b_q;
  logic              out_ind_q;
  logic [15:0]       out_period_q;

  logic              in_acc;
  logic              mine;
  logic              fading;
  logic              div_start;
  logic              div_done;
  logic [QUOT_W-1:0] div_quot;
  logic              emit;
  logic [7:0]        col_sel;
  logic [FT_W-1:0]   ft_diff;
  logic [19:0]       ft_full;
  logic [31:0]       start_eff;
  logic [31:0]       span;
  logic [32:0]       psum;
  logic [15:0]       period_new;
  logic [7:0]        speed_sum;
  logic [3:0]        speed_new;
  logic [ELAP_W:0]   elap_sum;

  assign in_acc = in_valid_i && !in_stall_o;
  assign mine   = (channel_i == listen_q);
  assign fading = (elapsed_q < {2'b00, ft_q});

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc && req_type_i == REQ_FRAME) begin
          state_d = running_q ? ST_SCALE : ST_EMIT;
        end
      end
      ST_SCALE:  state_d = ST_SEL;
      ST_SEL:    state_d = fading ? ST_MUL : ST_EMIT;
      ST_MUL:    state_d = ST_DSTART;
      ST_DSTART: state_d = ST_DWAIT;
      ST_DWAIT: begin
        if (div_done) begin
          state_d = (idx_q == 2'd2) ? ST_EMIT : ST_MUL;
        end
      end
      ST_EMIT: begin
        if (!out_valid_q || !out_stall_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    in_stall_o = 1'b1;
    div_start  = 1'b0;
    emit       = 1'b0;
    unique case (state_q)
      ST_IDLE:   in_stall_o = 1'b0;
      ST_DSTART: div_start  = 1'b1;
      ST_EMIT:   emit       = !out_valid_q || !out_stall_i;
      default: ;
    endcase
  end

  // Datapath helpers
  always_comb begin
    case (idx_q)
      2'd0:    col_sel = col_r_q;
      2'd1:    col_sel = col_g_q;
      default: col_sel = col_b_q;
    endcase
    ft_diff    = ft_q - elapsed_q[FT_W-1:0];
    ft_full    = period_q * speed_q;
    start_eff  = (clk_cnt_q == 5'd0) ? now_ms_i : clk_start_q;
    span       = now_ms_i - start_eff;
    psum       = {1'b0, span} + {17'd0, last_frame_q};
    period_new = (psum > 33'h0FFFF) ? 16'hFFFF : psum[15:0];
    speed_sum  = {1'b0, value_i} + 8'd15;
    speed_new  = (value_i == 7'd0) ? 4'd1 : speed_sum[7:4];
    elap_sum   = {1'b0, elapsed_q} + {5'd0, last_frame_q};
  end

  mtf_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (prod_q),
    .divisor_i  (ft_q),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      listen_q     <= 5'd1;
      clk_cnt_q    <= '0;
      clk_start_q  <= '0;
      period_q     <= 16'd1;
      last_frame_q <= '0;
      col_r_q      <= '0;
      col_g_q      <= '0;
      col_b_q      <= '0;
      running_q    <= 1'b0;
      speed_q      <= 4'd1;
      elapsed_q    <= '0;
      lamp_q       <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        listen_q <= cfg_wdata_i;
      end
      if (in_acc) begin
        unique case (req_type_i)
          REQ_CLOCK: begin
            clk_start_q <= start_eff;
            if (clk_cnt_q == LAST_CLOCK) begin
              clk_cnt_q <= '0;
              period_q  <= period_new;
            end else begin
              clk_cnt_q <= clk_cnt_q + 5'd1;
            end
          end
          REQ_START: clk_cnt_q <= '0;
          REQ_CTRL: begin
            if (mine) begin
              if (number_i == CC_RED)   col_r_q <= {value_i, 1'b0};
              if (number_i == CC_GREEN) col_g_q <= {value_i, 1'b0};
              if (number_i == CC_BLUE)  col_b_q <= {value_i, 1'b0};
            end
          end
          REQ_NOTE_ON: begin
            if (mine) begin
              lamp_q <= 1'b1;
              if (number_i == FLASH_NOTE) begin
                running_q <= 1'b1;
                speed_q   <= speed_new;
              end
            end
          end
          REQ_NOTE_OFF: begin
            if (mine) begin
              lamp_q <= 1'b0;
              if (number_i == FLASH_NOTE) begin
                running_q <= 1'b0;
                elapsed_q <= '0;
              end
            end
          end
          default: ;
        endcase
      end
      // Advance flash time and take the new frame length once the result is out
      if (emit) begin
        if (running_q) begin
          elapsed_q <= elap_sum[ELAP_W] ? {ELAP_W{1'b1}} : elap_sum[ELAP_W-1:0];
        end
        last_frame_q <= frame_q;
        out_valid_q  <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && req_type_i == REQ_FRAME) begin
      frame_q  <= frame_ms_i;
      res_q[0] <= '0;
      res_q[1] <= '0;
      res_q[2] <= '0;
    end
    if (state_q == ST_SCALE) begin
      ft_q <= ft_full[19:2];
    end
    if (state_q == ST_SEL) begin
      idx_q <= '0;
      // Zero fade length with no elapsed time shows the full colour
      if (!fading && elapsed_q == '0) begin
        res_q[0] <= col_r_q;
        res_q[1] <= col_g_q;
        res_q[2] <= col_b_q;
      end
    end
    if (state_q == ST_MUL) begin
      prod_q <= col_sel * ft_diff;
    end
    if (state_q == ST_DWAIT && div_done) begin
      res_q[idx_q] <= div_quot;
      idx_q        <= idx_q + 2'd1;
    end
    if (emit) begin
      out_r_q      <= res_q[0];
      out_g_q      <= res_q[1];
      out_b_q      <= res_q[2];
      out_ind_q    <= lamp_q;
      out_period_q <= period_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign red_o         = out_r_q;
  assign green_o       = out_g_q;
  assign blue_o        = out_b_q;
  assign indicator_o   = out_ind_q;
  assign beat_period_o = out_period_q;

endmodule
`default_nettype wire

>>> hw/rtl/mtf_div.sv
// Restoring divider, one quotient bit per cycle, for quotients known to fit QUOT_W bits.
// Depends on mtf_pkg for the operand widths.
`default_nettype none
module mtf_div (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  input  wire logic [mtf_pkg::DVD_W-1:0]  dividend_i,
  input  wire logic [mtf_pkg::FT_W-1:0]   divisor_i,
  output logic                            done_o,
  output logic [mtf_pkg::QUOT_W-1:0]      quot_o
);
  import mtf_pkg::*;

  logic [FT_W-1:0]    rem_q, rem_d;
  logic [FT_W-1:0]    div_q;
  logic [QUOT_W-1:0]  lo_q, lo_d;
  logic [2:0]         cnt_q;
  logic               busy_q;
  logic               done_q;
  logic [FT_W:0]      trial;
  logic [FT_W:0]      diff;
  logic               ge;

  // Dividend < 2^QUOT_W * divisor, so the top part starts below the divisor
  always_comb begin
    trial = {rem_q, lo_q[QUOT_W-1]};
    ge    = (trial >= {1'b0, div_q});
    diff  = trial - {1'b0, div_q};
    rem_d = ge ? diff[FT_W-1:0] : trial[FT_W-1:0];
    lo_d  = {lo_q[QUOT_W-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 3'd1;
        if (cnt_q == 3'(QUOT_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= dividend_i[DVD_W-1:QUOT_W];
      lo_q  <= dividend_i[QUOT_W-1:0];
      div_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      lo_q  <= lo_d;
    end
  end

  assign done_o = done_q;
  assign quot_o = lo_q;

endmodule
`default_nettype wire
